// ===== hw/rtl/bda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// Shared widths, register indexes, reset values, state codes and multiplier
// request/response types for the bidirectional anchor finder.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int SYM_W      = 8;
    localparam int POS_W      = 40;
    localparam int KMER_W     = 8;
    localparam int WIN_W      = 9;
    localparam int FP_W       = 61;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 61;

    localparam logic [FP_W-1:0] PRIME61 = {FP_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_BASE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEADING_POWER   = 3'd4;

    localparam logic [KMER_W-1:0] RST_KMER_LENGTH     = 8'd4;
    localparam logic [WIN_W-1:0]  RST_WINDOW_LENGTH   = 9'd16;
    localparam logic [POS_W-1:0]  RST_POSITION_OFFSET = '0;
    localparam logic [FP_W-1:0]   RST_HASH_BASE       = 61'd256;
    localparam logic [FP_W-1:0]   RST_LEADING_POWER   = 61'd4294967296;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_MUL1,
        S_MUL2_GO,
        S_MUL2,
        S_RING,
        S_FRONT_RD,
        S_FRONT_CHK,
        S_BACK_RD,
        S_BACK_FP,
        S_BACK_CHK,
        S_PUSH,
        S_MIN_RD,
        S_MIN_FP,
        S_MIN_SET,
        S_TIE_RD,
        S_TIE_FP,
        S_TIE_CHK,
        S_ROT_A,
        S_ROT_B,
        S_ROT_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic            start;
        logic [FP_W-1:0] a;
        logic [FP_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic            done;
        logic [FP_W-1:0] prod;
    } t_mul_rsp;

endpackage

// ===== hw/rtl/bda_sym_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_sym_if
// Symbol channel: one string symbol per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bda_sym_if;
    logic                      valid;
    logic                      ready;
    logic [bda_pkg::SYM_W-1:0] symbol;
    logic                      string_start;

    modport source (output valid, output symbol, output string_start, input ready);
    modport sink   (input valid, input symbol, input string_start, output ready);
endinterface

// ===== hw/rtl/bda_anchor_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_anchor_if
// Anchor channel: one anchor position per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bda_anchor_if;
    logic                      valid;
    logic                      ready;
    logic [bda_pkg::POS_W-1:0] anchor_position;

    modport source (output valid, output anchor_position, input ready);
    modport sink   (input valid, input anchor_position, output ready);
endinterface

// ===== hw/rtl/bda_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_ram
// Generic single-write, single-read synchronous RAM with registered read
// data (old data on a same-address read and write).
// ----------------------------------------------------------------------------
module bda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== hw/rtl/bda_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_mulmod
// Multicycle product modulo 2^61-1: four 32x32 partial products, one fold,
// one final reduction; the result and the done pulse are registered together at the end.
// ----------------------------------------------------------------------------
module bda_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bda_pkg::t_mul_req i_req,
    output bda_pkg::t_mul_rsp o_rsp
);

    localparam int FW   = bda_pkg::FP_W;
    localparam int HW   = 32;
    localparam int PW   = 2 * HW;
    localparam int AW   = 2 * FW;
    localparam logic [2:0] STEP_LAST_PP = 3'd3;
    localparam logic [2:0] STEP_FOLD    = 3'd4;
    localparam logic [2:0] STEP_FINAL   = 3'd5;

    logic          r_busy;
    logic [2:0]    r_step;
    logic          r_done;
    logic [FW-1:0] r_a;
    logic [FW-1:0] r_b;
    logic [AW-1:0] r_acc;
    logic [FW:0]   r_s;
    logic [FW-1:0] r_prod;

    logic [HW-1:0] op_a;
    logic [HW-1:0] op_b;
    logic [PW-1:0] pp;
    logic [AW-1:0] addend;
    logic [FW:0]   fin;
    logic [FW:0]   fin_red;

    always_comb begin
        op_a = r_step[1] ? HW'(r_a[FW-1:HW]) : r_a[HW-1:0];
        op_b = r_step[0] ? HW'(r_b[FW-1:HW]) : r_b[HW-1:0];
        pp   = op_a * op_b;
        if (r_step == STEP_LAST_PP) begin
            addend = AW'(pp) << PW;
        end else if (r_step[0] ^ r_step[1]) begin
            addend = AW'(pp) << HW;
        end else begin
            addend = AW'(pp);
        end
        fin     = {1'b0, r_s[FW-1:0]} + (FW+1)'(r_s[FW]);
        fin_red = (fin >= {1'b0, bda_pkg::PRIME61}) ? fin - {1'b0, bda_pkg::PRIME61} : fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_FINAL) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_step <= STEP_LAST_PP) begin
                r_acc <= r_acc + addend;
            end else if (r_step == STEP_FOLD) begin
                r_s <= {1'b0, r_acc[FW-1:0]} + {1'b0, r_acc[AW-1:FW]};
            end else begin
                r_prod <= fin_red[FW-1:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

endmodule

// ===== hw/rtl/bidirectional_anchor_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidirectional_anchor_finder
// Streaming reduced bidirectional anchors over Karp-Rabin fingerprints.
// ----------------------------------------------------------------------------
// One symbol is taken per transaction and at most one anchor position is
// returned for it, once a full window has arrived. Symbols, k-mer
// fingerprints and the monotone candidate deque live in three RAMs of
// WINDOW_MAX entries; one sequencer walks them. For each item it forms the
// fingerprint with one pass through the modular multiplier, or two once a
// symbol leaves the k-mer, drops stale candidates from the deque front and
// larger fingerprints from its back, selects the window minimum, and walks
// the tied candidates, comparing their rotations symbol by symbol. The
// input is taken only while the sequencer is idle; a finished anchor waits
// in the output register while the next symbol is already being processed.
// No clearing pass is needed after reset.
module bidirectional_anchor_finder #(
    parameter int WINDOW_MAX = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bda_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bda_sym_if.sink                        i_sym,
    bda_anchor_if.source                   o_anchor
);

    localparam int POS_W  = bda_pkg::POS_W;
    localparam int FP_W   = bda_pkg::FP_W;
    localparam int WIN_W  = bda_pkg::WIN_W;
    localparam int SYM_W  = bda_pkg::SYM_W;
    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int PTR_W  = $clog2(2 * WINDOW_MAX);
    localparam int CW     = (PTR_W + 1 > WIN_W + 1) ? PTR_W + 1 : WIN_W + 1;
    localparam int ENT_W  = POS_W + SLOT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_MAX);
    localparam logic [CW-1:0] SPAN_C  = CW'(2 * WINDOW_MAX);

    function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] a,
                                                   input logic [CW-1:0] b);
        logic [CW-1:0] ac;
        ac = CW'(a);
        if (ac >= b) return SLOT_W'(ac - b);
        return SLOT_W'(ac + DEPTH_C - b);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [CW-1:0] b);
        logic [CW-1:0] sum;
        sum = CW'(a) + b;
        if (sum >= DEPTH_C) return SLOT_W'(sum - DEPTH_C);
        return SLOT_W'(sum);
    endfunction

    function automatic logic [SLOT_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
        logic [CW-1:0] pc;
        pc = CW'(p);
        if (pc >= DEPTH_C) return SLOT_W'(pc - DEPTH_C);
        return SLOT_W'(pc);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [CW-1:0] pc;
        pc = CW'(p) + CW'(1);
        if (pc == SPAN_C) return '0;
        return PTR_W'(pc);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        if (p == '0) return PTR_W'(SPAN_C - CW'(1));
        return p - PTR_W'(1);
    endfunction

    function automatic logic [WIN_W-1:0] rot_off(input logic [POS_W-1:0] pos,
                                                 input logic [POS_W-1:0] j,
                                                 input logic [WIN_W-1:0] k,
                                                 input logic [WIN_W-1:0] w);
        logic [POS_W:0] x;
        x = {1'b0, pos - j} + (POS_W+1)'(k);
        if (x >= (POS_W+1)'(w)) x = x - (POS_W+1)'(w);
        return WIN_W'(x);
    endfunction

    // configuration
    logic [bda_pkg::KMER_W-1:0] r_kmer;
    logic [WIN_W-1:0]           r_win;
    logic [POS_W-1:0]           r_offset;
    logic [FP_W-1:0]            r_base;
    logic [FP_W-1:0]            r_lead;

    // control state
    bda_pkg::t_state r_state;
    bda_pkg::t_state n_state;
    logic [POS_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_slot;
    logic [FP_W-1:0]   r_rolling;
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic              r_out_valid;

    // item payload
    logic [SYM_W-1:0]  r_sym;
    logic [FP_W-1:0]   r_fp;
    logic [POS_W-1:0]  r_s;
    logic [SLOT_W-1:0] r_slot_s;
    logic [ENT_W-1:0]  r_best;
    logic [ENT_W-1:0]  r_e;
    logic [FP_W-1:0]   r_minfp;
    logic [PTR_W-1:0]  r_cur;
    logic [CW-1:0]     r_t;
    logic [WIN_W-1:0]  r_pa;
    logic [WIN_W-1:0]  r_pb;
    logic [WIN_W-1:0]  r_rc;
    logic [SYM_W-1:0]  r_ca;
    logic [POS_W-1:0]  r_out_pos;

    // memories
    logic              sym_we, sym_re;
    logic [SLOT_W-1:0] sym_waddr, sym_raddr;
    logic [SYM_W-1:0]  sym_q;
    logic              fp_we, fp_re;
    logic [SLOT_W-1:0] fp_waddr, fp_raddr;
    logic [FP_W-1:0]   fp_q;
    logic              deq_we, deq_re;
    logic [SLOT_W-1:0] deq_waddr, deq_raddr;
    logic [ENT_W-1:0]  deq_q;

    bda_pkg::t_mul_req mul_req;
    bda_pkg::t_mul_rsp mul_rsp;

    // derived values
    logic [WIN_W-1:0]  w_eff;
    logic [WIN_W-1:0]  k_eff;
    logic [CW-1:0]     w_c;
    logic [CW-1:0]     k_c;
    logic [CW-1:0]     dq_size;
    logic              in_fire;
    logic              out_free;
    logic              i_ge_k;
    logic [POS_W:0]    cnt_inc;
    logic              i1_ge_k;
    logic [SLOT_W-1:0] slot_next;
    logic [SLOT_W-1:0] slot_s_c;
    logic              win_full;
    logic [POS_W-1:0]  j_pos;
    logic [SLOT_W-1:0] slot_j;
    logic              front_pop;
    logic              back_pop;
    logic              rot_done;
    logic [WIN_W-1:0]  pa_inc;
    logic [WIN_W-1:0]  pb_inc;
    logic [FP_W:0]     fp_add;
    logic [FP_W:0]     fp_add_red;
    logic [FP_W-1:0]   fp_sub;

    always_comb begin
        if (r_win == '0) begin
            w_eff = WIN_W'(1);
        end else if (CW'(r_win) > DEPTH_C) begin
            w_eff = WIN_W'(DEPTH_C);
        end else begin
            w_eff = r_win;
        end
        if (r_kmer == '0) begin
            k_eff = WIN_W'(1);
        end else if (WIN_W'(r_kmer) > w_eff) begin
            k_eff = w_eff;
        end else begin
            k_eff = WIN_W'(r_kmer);
        end
        w_c = CW'(w_eff);
        k_c = CW'(k_eff);

        dq_size = (r_tail >= r_head) ? CW'(r_tail) - CW'(r_head)
                                     : CW'(r_tail) + SPAN_C - CW'(r_head);

        in_fire  = i_sym.valid && (r_state == bda_pkg::S_IDLE);
        out_free = !r_out_valid || o_anchor.ready;

        i_ge_k    = r_count >= POS_W'(k_eff);
        cnt_inc   = {1'b0, r_count} + (POS_W+1)'(1);
        i1_ge_k   = cnt_inc >= (POS_W+1)'(k_eff);
        slot_next = slot_add(r_slot, CW'(1));
        slot_s_c  = slot_sub(slot_next, k_c);
        win_full  = r_count >= POS_W'(w_eff);
        j_pos     = r_count - POS_W'(w_eff);
        slot_j    = slot_sub(r_slot, w_c);

        front_pop = (r_s - deq_q[ENT_W-1:SLOT_W]) > POS_W'(w_eff - k_eff);
        back_pop  = fp_q > r_fp;
        rot_done  = r_rc == w_eff;
        pa_inc    = (r_pa + WIN_W'(1) == w_eff) ? '0 : r_pa + WIN_W'(1);
        pb_inc    = (r_pb + WIN_W'(1) == w_eff) ? '0 : r_pb + WIN_W'(1);

        fp_add     = {1'b0, mul_rsp.prod} + (FP_W+1)'(r_sym);
        fp_add_red = (fp_add >= {1'b0, bda_pkg::PRIME61})
                   ? fp_add - {1'b0, bda_pkg::PRIME61} : fp_add;
        fp_sub     = (r_fp >= mul_rsp.prod) ? r_fp - mul_rsp.prod
                   : FP_W'({1'b0, r_fp} + {1'b0, bda_pkg::PRIME61} - {1'b0, mul_rsp.prod});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bda_pkg::S_IDLE:      if (in_fire) n_state = bda_pkg::S_LOAD;
            bda_pkg::S_LOAD:      n_state = bda_pkg::S_MUL1;
            bda_pkg::S_MUL1: begin
                if (mul_rsp.done) begin
                    n_state = i_ge_k ? bda_pkg::S_MUL2_GO : bda_pkg::S_RING;
                end
            end
            bda_pkg::S_MUL2_GO:   n_state = bda_pkg::S_MUL2;
            bda_pkg::S_MUL2:      if (mul_rsp.done) n_state = bda_pkg::S_RING;
            bda_pkg::S_RING:      n_state = i1_ge_k ? bda_pkg::S_FRONT_RD : bda_pkg::S_IDLE;
            bda_pkg::S_FRONT_RD: begin
                n_state = (dq_size == '0) ? bda_pkg::S_BACK_RD : bda_pkg::S_FRONT_CHK;
            end
            bda_pkg::S_FRONT_CHK: begin
                n_state = front_pop ? bda_pkg::S_FRONT_RD : bda_pkg::S_BACK_RD;
            end
            bda_pkg::S_BACK_RD: begin
                n_state = (dq_size == '0) ? bda_pkg::S_PUSH : bda_pkg::S_BACK_FP;
            end
            bda_pkg::S_BACK_FP:   n_state = bda_pkg::S_BACK_CHK;
            bda_pkg::S_BACK_CHK:  n_state = back_pop ? bda_pkg::S_BACK_RD : bda_pkg::S_PUSH;
            bda_pkg::S_PUSH:      n_state = win_full ? bda_pkg::S_MIN_RD : bda_pkg::S_IDLE;
            bda_pkg::S_MIN_RD:    n_state = bda_pkg::S_MIN_FP;
            bda_pkg::S_MIN_FP:    n_state = bda_pkg::S_MIN_SET;
            bda_pkg::S_MIN_SET:   n_state = bda_pkg::S_TIE_RD;
            bda_pkg::S_TIE_RD: begin
                n_state = (r_t >= dq_size) ? bda_pkg::S_EMIT : bda_pkg::S_TIE_FP;
            end
            bda_pkg::S_TIE_FP:    n_state = bda_pkg::S_TIE_CHK;
            bda_pkg::S_TIE_CHK: begin
                n_state = (fp_q != r_minfp) ? bda_pkg::S_EMIT : bda_pkg::S_ROT_A;
            end
            bda_pkg::S_ROT_A:     n_state = rot_done ? bda_pkg::S_TIE_RD : bda_pkg::S_ROT_B;
            bda_pkg::S_ROT_B:     n_state = bda_pkg::S_ROT_CMP;
            bda_pkg::S_ROT_CMP: begin
                n_state = (sym_q != r_ca) ? bda_pkg::S_TIE_RD : bda_pkg::S_ROT_A;
            end
            bda_pkg::S_EMIT:      if (out_free) n_state = bda_pkg::S_IDLE;
            default:              n_state = bda_pkg::S_IDLE;
        endcase
    end

    // memory and multiplier control
    always_comb begin
        sym_we    = 1'b0;
        sym_waddr = r_slot;
        sym_re    = 1'b0;
        sym_raddr = slot_add(slot_j, CW'(r_pa));
        fp_we     = 1'b0;
        fp_waddr  = slot_s_c;
        fp_re     = 1'b0;
        fp_raddr  = deq_q[SLOT_W-1:0];
        deq_we    = 1'b0;
        deq_waddr = ptr_idx(r_tail);
        deq_re    = 1'b0;
        deq_raddr = ptr_idx(r_head);
        mul_req.start = 1'b0;
        mul_req.a     = r_rolling;
        mul_req.b     = r_base;
        unique case (r_state)
            bda_pkg::S_LOAD: begin
                sym_we        = 1'b1;
                sym_re        = 1'b1;
                sym_raddr     = slot_sub(r_slot, k_c);
                mul_req.start = 1'b1;
            end
            bda_pkg::S_MUL2_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = FP_W'(sym_q);
                mul_req.b     = r_lead;
            end
            bda_pkg::S_RING:     fp_we = i1_ge_k;
            bda_pkg::S_FRONT_RD: deq_re = dq_size != '0;
            bda_pkg::S_BACK_RD: begin
                deq_re    = dq_size != '0;
                deq_raddr = ptr_idx(ptr_dec(r_tail));
            end
            bda_pkg::S_BACK_FP:  fp_re = 1'b1;
            bda_pkg::S_PUSH:     deq_we = 1'b1;
            bda_pkg::S_MIN_RD:   deq_re = 1'b1;
            bda_pkg::S_MIN_FP:   fp_re = 1'b1;
            bda_pkg::S_TIE_RD: begin
                deq_re    = r_t < dq_size;
                deq_raddr = ptr_idx(r_cur);
            end
            bda_pkg::S_TIE_FP:   fp_re = 1'b1;
            bda_pkg::S_ROT_A:    sym_re = !rot_done;
            bda_pkg::S_ROT_B: begin
                sym_re    = 1'b1;
                sym_raddr = slot_add(slot_j, CW'(r_pb));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer      <= bda_pkg::RST_KMER_LENGTH;
            r_win       <= bda_pkg::RST_WINDOW_LENGTH;
            r_offset    <= bda_pkg::RST_POSITION_OFFSET;
            r_base      <= bda_pkg::RST_HASH_BASE;
            r_lead      <= bda_pkg::RST_LEADING_POWER;
            r_state     <= bda_pkg::S_IDLE;
            r_count     <= '0;
            r_slot      <= '0;
            r_rolling   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bda_pkg::REG_KMER_LENGTH:     r_kmer   <= i_cfg_data[bda_pkg::KMER_W-1:0];
                    bda_pkg::REG_WINDOW_LENGTH:   r_win    <= i_cfg_data[WIN_W-1:0];
                    bda_pkg::REG_POSITION_OFFSET: r_offset <= i_cfg_data[POS_W-1:0];
                    bda_pkg::REG_HASH_BASE: begin
                        r_base <= (i_cfg_data == bda_pkg::PRIME61) ? '0 : i_cfg_data;
                    end
                    bda_pkg::REG_LEADING_POWER: begin
                        r_lead <= (i_cfg_data == bda_pkg::PRIME61) ? '0 : i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (in_fire && i_sym.string_start) begin
                r_count   <= '0;
                r_slot    <= '0;
                r_rolling <= '0;
                r_head    <= '0;
                r_tail    <= '0;
            end
            if (r_state == bda_pkg::S_RING) begin
                r_rolling <= r_fp;
                r_count   <= cnt_inc[POS_W-1:0];
                r_slot    <= slot_next;
            end
            if (r_state == bda_pkg::S_FRONT_CHK && front_pop) begin
                r_head <= ptr_inc(r_head);
            end
            if (r_state == bda_pkg::S_BACK_CHK && back_pop) begin
                r_tail <= ptr_dec(r_tail);
            end
            if (r_state == bda_pkg::S_PUSH) begin
                if (dq_size >= DEPTH_C) r_head <= ptr_inc(r_head);
                r_tail <= ptr_inc(r_tail);
            end
            if (r_state == bda_pkg::S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_anchor.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) r_sym <= i_sym.symbol;
        unique case (r_state)
            bda_pkg::S_MUL1:    if (mul_rsp.done) r_fp <= fp_add_red[FP_W-1:0];
            bda_pkg::S_MUL2:    if (mul_rsp.done) r_fp <= fp_sub;
            bda_pkg::S_RING: begin
                r_s      <= POS_W'(cnt_inc - (POS_W+1)'(k_eff));
                r_slot_s <= slot_s_c;
            end
            bda_pkg::S_MIN_RD: begin
                r_cur <= ptr_inc(r_head);
                r_t   <= CW'(1);
            end
            bda_pkg::S_MIN_FP:  r_best  <= deq_q;
            bda_pkg::S_MIN_SET: r_minfp <= fp_q;
            bda_pkg::S_TIE_FP:  r_e     <= deq_q;
            bda_pkg::S_TIE_CHK: begin
                r_pa <= rot_off(r_best[ENT_W-1:SLOT_W], j_pos, k_eff, w_eff);
                r_pb <= rot_off(r_e[ENT_W-1:SLOT_W], j_pos, k_eff, w_eff);
                r_rc <= '0;
            end
            bda_pkg::S_ROT_A: begin
                if (rot_done) begin
                    r_best <= r_e;
                    r_t    <= r_t + CW'(1);
                    r_cur  <= ptr_inc(r_cur);
                end
            end
            bda_pkg::S_ROT_B:   r_ca <= sym_q;
            bda_pkg::S_ROT_CMP: begin
                if (sym_q != r_ca) begin
                    if (sym_q < r_ca) r_best <= r_e;
                    r_t   <= r_t + CW'(1);
                    r_cur <= ptr_inc(r_cur);
                end else begin
                    r_pa <= pa_inc;
                    r_pb <= pb_inc;
                    r_rc <= r_rc + WIN_W'(1);
                end
            end
            bda_pkg::S_EMIT: begin
                if (out_free) r_out_pos <= r_best[ENT_W-1:SLOT_W] + r_offset;
            end
            default: begin
            end
        endcase
    end

    bda_ram #(.WIDTH(SYM_W), .DEPTH(WINDOW_MAX)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (sym_waddr),
        .i_wdata (r_sym),
        .i_re    (sym_re),
        .i_raddr (sym_raddr),
        .o_rdata (sym_q)
    );

    bda_ram #(.WIDTH(FP_W), .DEPTH(WINDOW_MAX)) u_fp_ram (
        .i_clk   (i_clk),
        .i_we    (fp_we),
        .i_waddr (fp_waddr),
        .i_wdata (r_fp),
        .i_re    (fp_re),
        .i_raddr (fp_raddr),
        .o_rdata (fp_q)
    );

    bda_ram #(.WIDTH(ENT_W), .DEPTH(WINDOW_MAX)) u_deq_ram (
        .i_clk   (i_clk),
        .i_we    (deq_we),
        .i_waddr (deq_waddr),
        .i_wdata ({r_s, r_slot_s}),
        .i_re    (deq_re),
        .i_raddr (deq_raddr),
        .o_rdata (deq_q)
    );

    bda_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign i_sym.ready              = r_state == bda_pkg::S_IDLE;
    assign o_anchor.valid           = r_out_valid;
    assign o_anchor.anchor_position = r_out_pos;

endmodule

// ===== hw/rtl/bda_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_checker
// Port-level checks of the anchor finder, bound to the top level.
// ----------------------------------------------------------------------------
module bda_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [bda_pkg::POS_W-1:0] i_anchor_position
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("anchor valid after reset");

    a_one_symbol_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("symbol channel ready right after a transaction");

    a_no_instant_anchor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(in_acc))
        else $error("anchor appeared one cycle after a symbol");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_anchor_position))
        else $error("stalled anchor changed");

endmodule

bind bidirectional_anchor_finder bda_checker u_bda_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_sym.valid),
    .i_in_ready        (i_sym.ready),
    .i_out_valid       (o_anchor.valid),
    .i_out_ready       (o_anchor.ready),
    .i_anchor_position (o_anchor.anchor_position)
);

// ===== dv/anchor_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_checker
// Watches the configuration port and both channels of the anchor finder,
// keeps its own rolling fingerprint, symbol ring and candidate deque, works
// out any anchor due for each accepted symbol and compares each anchor
// transaction against the oldest one still due.
// ----------------------------------------------------------------------------
module anchor_checker
    import bda_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bda_sym_if                    i_sym,
    bda_anchor_if                 i_anchor,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int SLOTS = 256;
    localparam logic [POS_W-1:0] POS_MASK = {POS_W{1'b1}};

    logic [KMER_W-1:0] kmer_len;
    logic [WIN_W-1:0]  win_len;
    logic [POS_W-1:0]  offset;
    logic [FP_W-1:0]   base;
    logic [FP_W-1:0]   lead_pow;

    logic [SYM_W-1:0]  sym_ring [SLOTS];
    logic [FP_W-1:0]   fp_ring  [SLOTS];
    logic [POS_W-1:0]  starts   [SLOTS];
    logic [8:0]        head;
    logic [8:0]        tail;
    logic [FP_W-1:0]   roll_fp;
    logic [POS_W-1:0]  count;

    logic [POS_W-1:0]  anchors_due [$];

    function automatic logic [FP_W-1:0] fold61(logic [127:0] x);
        repeat (3) x = (x & {67'b0, PRIME61}) + (x >> FP_W);
        if (x >= {67'b0, PRIME61}) x = x - {67'b0, PRIME61};
        return x[FP_W-1:0];
    endfunction

    function automatic logic [FP_W-1:0] mul61(logic [FP_W-1:0] a, logic [FP_W-1:0] b);
        return fold61({67'b0, a} * {67'b0, b});
    endfunction

    function automatic logic [POS_W-1:0] start_at(logic [8:0] t);
        logic [8:0] idx;
        idx = head + t;
        return starts[idx[7:0]];
    endfunction

    // 1 when the rotation after start b is not larger than the one after a
    function automatic bit later_rotation_wins(longint unsigned j, longint unsigned w,
                                               longint unsigned k, logic [POS_W-1:0] a,
                                               logic [POS_W-1:0] b);
        longint unsigned oa, ob, pa, pb;
        logic [SYM_W-1:0] ca, cb;
        oa = ((({24'b0, a} - j) & POS_MASK) + k) % w;
        ob = ((({24'b0, b} - j) & POS_MASK) + k) % w;
        for (longint unsigned t = 0; t < w; t++) begin
            pa = j + (oa + t) % w;
            pb = j + (ob + t) % w;
            ca = sym_ring[pa[7:0]];
            cb = sym_ring[pb[7:0]];
            if (cb < ca) return 1;
            if (cb > ca) return 0;
        end
        return 1;
    endfunction

    task automatic predict_anchor(logic [SYM_W-1:0] c, logic first);
        longint unsigned w, k, i, s, j, lp;
        logic [SYM_W-1:0] leaving;
        logic [FP_W-1:0] fp, sub, minfp;
        logic [POS_W-1:0] best, e;
        logic [8:0] n, back;
        w = win_len;
        k = kmer_len;
        if (w > SLOTS) w = SLOTS;
        if (w < 1) w = 1;
        if (k < 1) k = 1;
        if (k > w) k = w;
        if (first) begin
            count = '0;
            head = '0;
            tail = '0;
            roll_fp = '0;
        end
        i = count;
        lp = i - k;
        leaving = sym_ring[lp[7:0]];
        sym_ring[i[7:0]] = c;
        fp = fold61({67'b0, mul61(roll_fp, fold61({67'b0, base}))} + c);
        if (i >= k) begin
            sub = mul61({53'b0, leaving}, fold61({67'b0, lead_pow}));
            fp = (fp >= sub) ? fp - sub : fp + PRIME61 - sub;
        end
        roll_fp = fp;
        count = i + 1;
        if (i + 1 >= k) begin
            s = i + 1 - k;
            fp_ring[s[7:0]] = fp;
            while (tail != head && ((s - start_at(0)) & POS_MASK) > w - k)
                head = head + 1;
            back = tail - 1;
            while (tail != head && fp_ring[starts[back[7:0]][7:0]] > fp) begin
                tail = tail - 1;
                back = tail - 1;
            end
            n = tail - head;
            if (n >= SLOTS) head = head + 1;
            starts[tail[7:0]] = s;
            tail = tail + 1;
        end
        n = tail - head;
        if (i + 1 >= w && n > 0) begin
            j = i + 1 - w;
            best = start_at(0);
            minfp = fp_ring[best[7:0]];
            for (int t = 1; t < n; t++) begin
                e = start_at(t);
                if (fp_ring[e[7:0]] != minfp) break;
                if (later_rotation_wins(j, w, k, best, e)) best = e;
            end
            anchors_due.push_back(best + offset);
        end
    endtask

    always @(posedge i_clk) begin
        logic [POS_W-1:0] due;
        if (!i_rst_n) begin
            kmer_len = RST_KMER_LENGTH;
            win_len = RST_WINDOW_LENGTH;
            offset = RST_POSITION_OFFSET;
            base = RST_HASH_BASE;
            lead_pow = RST_LEADING_POWER;
            head = '0;
            tail = '0;
            roll_fp = '0;
            count = '0;
            anchors_due.delete();
            o_errors = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KMER_LENGTH:     kmer_len = i_cfg_data[KMER_W-1:0];
                    REG_WINDOW_LENGTH:   win_len = i_cfg_data[WIN_W-1:0];
                    REG_POSITION_OFFSET: offset = i_cfg_data[POS_W-1:0];
                    REG_HASH_BASE:       base = i_cfg_data & PRIME61;
                    REG_LEADING_POWER:   lead_pow = i_cfg_data & PRIME61;
                    default: ;
                endcase
            end
            if (i_sym.valid && i_sym.ready)
                predict_anchor(i_sym.symbol, i_sym.string_start);
            if (i_anchor.valid && i_anchor.ready) begin
                if (anchors_due.size() == 0) begin
                    $error("anchor_position: expected none, got %0h", i_anchor.anchor_position);
                    o_errors++;
                end else begin
                    due = anchors_due.pop_front();
                    o_checked++;
                    if (due !== i_anchor.anchor_position) begin
                        $error("anchor_position: expected %0h, got %0h",
                               due, i_anchor.anchor_position);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = anchors_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives symbol strings into the anchor finder under a series of register
// settings, with random gaps and output stalls; the anchor checker predicts
// and compares every anchor and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import bda_pkg::*;

    localparam int SETTLE = 5000;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bda_sym_if    sym_ch ();
    bda_anchor_if anchor_ch ();

    int errors, pending, checked;
    int items_sent = 0;
    int settings = 0;
    bit quiet = 0;
    int stall_left = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    bidirectional_anchor_finder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sym       (sym_ch),
        .o_anchor    (anchor_ch)
    );

    anchor_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sym       (sym_ch),
        .i_anchor    (anchor_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        sym_ch.valid = 1'b0;
        sym_ch.symbol = '0;
        sym_ch.string_start = 1'b0;
        anchor_ch.ready = 1'b0;
    end

    // hold ready low for a drawn number of cycles after each transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            anchor_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (anchor_ch.ready && anchor_ch.valid) begin
            stall_left = quiet ? 0 : $urandom_range(0, 19);
            if (stall_left != 0) anchor_ch.ready <= 1'b0;
        end else if (!anchor_ch.ready) begin
            if (stall_left > 0) stall_left--;
            if (stall_left == 0) anchor_ch.ready <= 1'b1;
        end
    end

    initial begin
        #200_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic [FP_W-1:0] power61(logic [FP_W-1:0] b, int e);
        logic [127:0] r;
        r = 1;
        repeat (e) r = (r * b) % PRIME61;
        return r[FP_W-1:0];
    endfunction

    function automatic logic [FP_W-1:0] rand61();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[FP_W-1:0] % PRIME61;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(int k, int w, logic [POS_W-1:0] off,
                                  logic [FP_W-1:0] b, logic [FP_W-1:0] lp);
        write_reg(REG_KMER_LENGTH, k);
        write_reg(REG_WINDOW_LENGTH, w);
        write_reg(REG_POSITION_OFFSET, off);
        write_reg(REG_HASH_BASE, b);
        write_reg(REG_LEADING_POWER, lp);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic send_symbol(logic [SYM_W-1:0] c, logic first);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            sym_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sym_ch.valid <= 1'b1;
        sym_ch.symbol <= c;
        sym_ch.string_start <= first;
        do @(posedge i_clk); while (!(sym_ch.valid && sym_ch.ready));
        items_sent++;
    endtask

    task automatic drain();
        sym_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int k, w, weff, keff, alpha, lo, left, n;
        logic [FP_W-1:0] b, lp;
        logic [POS_W-1:0] off;
        logic [SYM_W-1:0] c;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: short string, then a full one with extreme symbols
        send_symbol(8'd255, 1'b1);
        send_symbol(8'd0, 1'b0);
        send_symbol(8'd1, 1'b0);
        for (int t = 0; t < 17; t++) begin
            c = (t % 3 == 0) ? 8'd0 : ((t % 3 == 1) ? 8'd255 : 8'($urandom));
            send_symbol(c, t == 0);
        end
        drain();

        // equal k-mers everywhere, offset wraps past the top position
        apply_settings(1, 3, POS_MAX, PRIME61 - 1, rand61());
        for (int t = 0; t < 6; t++) send_symbol(8'd7, t == 0);
        drain();

        for (int phase = 0; phase < 16; phase++) begin
            quiet = (phase % 5 == 3);
            n = $urandom_range(0, 9);
            if (n < 6) w = $urandom_range(2, 16);
            else if (n < 8) w = $urandom_range(17, 64);
            else if (n == 8) w = $urandom_range(200, 256);
            else begin
                n = $urandom_range(0, 3);
                w = (n == 0) ? 0 : (n == 1) ? 1 : (n == 2) ? 300 : 511;
            end
            weff = (w > 256) ? 256 : (w < 1 ? 1 : w);
            n = $urandom_range(0, 9);
            k = (n == 0) ? 0 : (n == 1) ? 255 : (n == 2) ? weff : $urandom_range(1, weff);
            keff = (k < 1) ? 1 : (k > weff ? weff : k);
            n = $urandom_range(0, 5);
            b = (n == 0) ? '0 : (n == 1) ? 1 : (n == 2) ? PRIME61 - 1 : rand61();
            lp = ($urandom_range(0, 3) == 0) ? rand61() : power61(b, keff);
            off = ($urandom_range(0, 4) == 0) ? POS_MAX : {$urandom, $urandom};
            apply_settings(k, w, off, b, lp);
            if (weff <= 16) alpha = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(1, 4);
            else if (weff <= 64) alpha = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(2, 16);
            else alpha = 256;
            lo = $urandom_range(0, 256 - ((alpha == 256) ? 256 : alpha));
            left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3 * weff);
            for (int t = 0; t < 100; t++) begin
                c = (alpha == 256) ? 8'($urandom) : 8'(lo + $urandom_range(0, alpha - 1));
                if (left == 0) begin
                    left = $urandom_range(1, 3 * weff + 4);
                    send_symbol(c, 1'b1);
                end else begin
                    send_symbol(c, 1'b0);
                end
                left--;
            end
            drain();
        end

        if (pending != 0) $error("anchor_position: %0d expected anchors never came", pending);
        $display("covered %0d symbols under %0d register settings", items_sent, settings);
        $display("compared %0d anchors", checked);
        if (errors == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
